FILE: src/rgbhr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgbhr_pkg: shared types and constants for the RGB hue rotation pipeline
// Fixed-point formats, derived widths and the sector code of the hexcone model.
// ----------------------------------------------------------------------------
package rgbhr_pkg;

    localparam int HUE_FRAC_BITS = 6;
    localparam int SECTOR_UNITS  = 60 << HUE_FRAC_BITS;
    localparam int TURN_UNITS    = 6 * SECTOR_UNITS;
    localparam int HUE_W         = $clog2(TURN_UNITS);

    localparam int CH_W  = 8;
    localparam int AMT_W = 16;

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 24;

    // hue numerator (base * d + n) stays below 6 * 255
    localparam int NUM_W = $clog2(6 * 255);
    localparam int X_MAX = 2 * (6 * 255 - 1) * SECTOR_UNITS + 255;
    localparam int XW    = $clog2(X_MAX + 1);
    localparam int DSR_W = CH_W + 1;
    localparam int CMP_W = (XW > DSR_W + HUE_W) ? XW : DSR_W + HUE_W;

    // amount mod turn: offset-binary amount times a reciprocal, exact for 16 bits
    localparam int    AMT_SH    = AMT_W + HUE_W;
    localparam longint AMT_MUL  = ((longint'(1) << AMT_SH) + TURN_UNITS - 1) / TURN_UNITS;
    localparam int    AMT_MUL_W = $clog2(AMT_MUL + 1);
    localparam int    PA_W      = AMT_W + AMT_MUL_W;
    localparam int    AQ_W      = $clog2(((1 << AMT_W) - 1) / TURN_UNITS + 2);
    localparam int    AMT_OFF   = (1 << (AMT_W - 1)) % TURN_UNITS;

    // middle channel: round(d * w / S) = floor((2dw + S) / (15 << (F + 3)))
    localparam int SEC_W     = $clog2(SECTOR_UNITS + 1);
    localparam int PROD_W    = CH_W + SEC_W;
    localparam int Y_W       = PROD_W + 2;
    localparam int ROUND_SH  = HUE_FRAC_BITS + 3;
    localparam int V_MAX     = (511 * SECTOR_UNITS) >> ROUND_SH;
    localparam int V_W       = $clog2(V_MAX + 1);
    localparam int DIV15_MUL = 4370;
    localparam int DIV15_SH  = 16;
    localparam int MUL15_W   = 13;
    localparam int TW        = V_W + MUL15_W;

    typedef struct packed {
        logic             mode;
        logic [AMT_W-1:0] ua;
        logic [CH_W-1:0]  mx;
        logic [CH_W-1:0]  mn;
        logic [CH_W-1:0]  d;
    } side_t;

    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } sector_t;

endpackage
`default_nettype wire

FILE: src/rgb_hue_rotate_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_hue_rotate_top: RGB hue rotation
// Converts a pixel to hue, shifts or replaces the hue, converts back to RGB.
// ----------------------------------------------------------------------------
// Hue resolution is 1/64 degree.
// Throughput: one pixel per cycle while the output is not stalled; the hue divider is a restoring divider
// with one quotient bit per pipeline stage.
// The whole pipeline holds while the output word waits for m_axis_tready.
// Reset (aresetn low, synchronous) clears all stage valid bits; data is kept.
module rgb_hue_rotate_top (
    input  wire  logic                           aclk,
    input  wire  logic                           aresetn,
    input  wire  logic                           s_axis_tvalid,
    output logic                                 s_axis_tready,
    // red_in [7:0], green_in [15:8], blue_in [23:16], hue_amount [39:24]
    input  wire  logic [rgbhr_pkg::S_DATA_W-1:0] s_axis_tdata,
    // mode [0]
    input  wire  logic [0:0]                     s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire  logic                           m_axis_tready,
    // red_out [7:0], green_out [15:8], blue_out [23:16]
    output logic [rgbhr_pkg::M_DATA_W-1:0]       m_axis_tdata
);
    import rgbhr_pkg::*;

    localparam int QW = HUE_W;

    logic en;

    // front stage
    logic [CH_W-1:0]  in_r, in_g, in_b, in_mx, in_mn, in_d;
    logic [NUM_W+1:0] num_wide;
    logic [NUM_W-1:0] num;
    side_t            in_side;

    // divider stages
    logic             div_vld_reg  [0:QW];
    side_t            div_side_reg [0:QW];
    logic [XW-1:0]    div_rem_reg  [0:QW];
    logic [QW-1:0]    div_quo_reg  [0:QW];

    // post stages
    logic             p1_vld_reg, p2_vld_reg, p3_vld_reg, p4_vld_reg, p5_vld_reg;
    logic             p6_vld_reg, out_vld_reg;
    side_t            p1_side_reg, p2_side_reg, p3_side_reg, p4_side_reg;
    side_t            p5_side_reg, p6_side_reg;
    logic [HUE_W-1:0] p1_q_reg, p2_q_reg, h_reg;
    logic [HUE_W-1:0] q_next;
    logic [PA_W-1:0]  p1_pa_reg;
    logic [HUE_W-1:0] p2_ra_reg;
    logic [AQ_W-1:0]  qa;
    logic [AMT_W-1:0] ra_wide;
    logic [HUE_W:0]   a_mod, hue_sum;
    logic [HUE_W-1:0] h_next;
    logic [2:0]       k_cnt;
    logic [SEC_W-1:0] pos, w_next;
    sector_t          p4_sec_reg, p5_sec_reg, p6_sec_reg;
    logic [SEC_W-1:0] p4_w_reg;
    logic [PROD_W-1:0] p5_prod_reg;
    logic [Y_W-1:0]   y_val;
    logic [V_W-1:0]   v_val;
    logic [TW-1:0]    p6_t_reg;
    logic [CH_W-1:0]  mid, ro, go, bo;
    logic [M_DATA_W-1:0] out_data_reg;

    assign en            = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

    // ---------------- front: channel extremes and hue numerator
    always_comb begin
        in_r  = s_axis_tdata[7:0];
        in_g  = s_axis_tdata[15:8];
        in_b  = s_axis_tdata[23:16];
        in_mx = (in_r > in_g) ? in_r : in_g;
        in_mx = (in_mx > in_b) ? in_mx : in_b;
        in_mn = (in_r < in_g) ? in_r : in_g;
        in_mn = (in_mn < in_b) ? in_mn : in_b;
        in_d  = in_mx - in_mn;
        if (in_mx == in_r) begin
            num_wide = (NUM_W+2)'(in_g) - (NUM_W+2)'(in_b);
            if (num_wide[NUM_W+1]) begin
                num_wide = num_wide + (NUM_W+2)'(6) * (NUM_W+2)'(in_d);
            end
        end else if (in_mx == in_g) begin
            num_wide = (NUM_W+2)'(2) * (NUM_W+2)'(in_d) + (NUM_W+2)'(in_b)
                     - (NUM_W+2)'(in_r);
        end else begin
            num_wide = (NUM_W+2)'(4) * (NUM_W+2)'(in_d) + (NUM_W+2)'(in_r)
                     - (NUM_W+2)'(in_g);
        end
        num = num_wide[NUM_W-1:0];
        in_side.mode = s_axis_tuser[0];
        // offset binary: amount + 2^15
        in_side.ua   = {~s_axis_tdata[39], s_axis_tdata[38:24]};
        in_side.mx   = in_mx;
        in_side.mn   = in_mn;
        in_side.d    = in_d;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            div_side_reg[0] <= in_side;
            div_rem_reg[0]  <= XW'(num) * XW'(2 * SECTOR_UNITS) + XW'(in_d);
            div_quo_reg[0]  <= '0;
        end
    end

    // ---------------- restoring divider, one quotient bit per stage
    for (genvar j = 1; j <= QW; j++) begin : g_div
        localparam int BIT = QW - j;
        logic [CMP_W-1:0] dsr_sh;
        logic [CMP_W-1:0] rem_ext;
        logic             ge;

        always_comb begin
            dsr_sh  = CMP_W'({div_side_reg[j-1].d, 1'b0}) << BIT;
            rem_ext = CMP_W'(div_rem_reg[j-1]);
            ge      = rem_ext >= dsr_sh;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                div_side_reg[j] <= div_side_reg[j-1];
                div_rem_reg[j]  <= ge ? XW'(rem_ext - dsr_sh) : div_rem_reg[j-1];
                div_quo_reg[j]  <= div_quo_reg[j-1] | (QW'(ge) << BIT);
            end
        end
    end

    // ---------------- post stages
    always_comb begin
        // grey pixels have hue 0; a hue that rounds to a full turn wraps to 0
        if (div_side_reg[QW].d == '0 || div_quo_reg[QW] >= QW'(TURN_UNITS)) begin
            q_next = '0;
        end else begin
            q_next = div_quo_reg[QW];
        end

        qa      = AQ_W'(p1_pa_reg >> AMT_SH);
        ra_wide = p1_side_reg.ua - AMT_W'(qa * TURN_UNITS);

        if (p2_ra_reg >= HUE_W'(AMT_OFF)) begin
            a_mod = (HUE_W+1)'(p2_ra_reg) - (HUE_W+1)'(AMT_OFF);
        end else begin
            a_mod = (HUE_W+1)'(p2_ra_reg) + (HUE_W+1)'(TURN_UNITS - AMT_OFF);
        end
        hue_sum = p2_side_reg.mode ? a_mod : (HUE_W+1)'(p2_q_reg) + a_mod;
        if (hue_sum >= (HUE_W+1)'(TURN_UNITS)) begin
            hue_sum = hue_sum - (HUE_W+1)'(TURN_UNITS);
        end
        h_next = hue_sum[HUE_W-1:0];
    end

    always_comb begin
        k_cnt = '0;
        for (int j = 1; j < 6; j++) begin
            if (h_reg >= HUE_W'(j * SECTOR_UNITS)) begin
                k_cnt = k_cnt + 3'd1;
            end
        end
        pos    = SEC_W'(h_reg - HUE_W'(k_cnt * SECTOR_UNITS));
        w_next = k_cnt[0] ? SEC_W'(SECTOR_UNITS) - pos : pos;

        y_val = Y_W'({p5_prod_reg, 1'b0}) + Y_W'(SECTOR_UNITS);
        v_val = V_W'(y_val >> ROUND_SH);

        mid = p6_side_reg.mn + CH_W'(p6_t_reg >> DIV15_SH);
        case (p6_sec_reg)
            SEC_RED_YEL: begin ro = p6_side_reg.mx; go = mid;            bo = p6_side_reg.mn; end
            SEC_YEL_GRN: begin ro = mid;            go = p6_side_reg.mx; bo = p6_side_reg.mn; end
            SEC_GRN_CYN: begin ro = p6_side_reg.mn; go = p6_side_reg.mx; bo = mid;            end
            SEC_CYN_BLU: begin ro = p6_side_reg.mn; go = mid;            bo = p6_side_reg.mx; end
            SEC_BLU_MAG: begin ro = mid;            go = p6_side_reg.mn; bo = p6_side_reg.mx; end
            default:     begin ro = p6_side_reg.mx; go = p6_side_reg.mn; bo = mid;            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_side_reg  <= div_side_reg[QW];
            p1_q_reg     <= q_next;
            p1_pa_reg    <= PA_W'(div_side_reg[QW].ua) * PA_W'(AMT_MUL);

            p2_side_reg  <= p1_side_reg;
            p2_q_reg     <= p1_q_reg;
            p2_ra_reg    <= HUE_W'(ra_wide);

            p3_side_reg  <= p2_side_reg;
            h_reg        <= h_next;

            p4_side_reg  <= p3_side_reg;
            p4_sec_reg   <= sector_t'(k_cnt);
            p4_w_reg     <= w_next;

            p5_side_reg  <= p4_side_reg;
            p5_sec_reg   <= p4_sec_reg;
            p5_prod_reg  <= PROD_W'(p4_side_reg.d) * PROD_W'(p4_w_reg);

            p6_side_reg  <= p5_side_reg;
            p6_sec_reg   <= p5_sec_reg;
            p6_t_reg     <= TW'(v_val) * TW'(DIV15_MUL);

            out_data_reg <= {bo, go, ro};
        end
    end

    // valid bits advance with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j <= QW; j++) begin
                div_vld_reg[j] <= 1'b0;
            end
            p1_vld_reg  <= 1'b0;
            p2_vld_reg  <= 1'b0;
            p3_vld_reg  <= 1'b0;
            p4_vld_reg  <= 1'b0;
            p5_vld_reg  <= 1'b0;
            p6_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            div_vld_reg[0] <= s_axis_tvalid;
            for (int j = 1; j <= QW; j++) begin
                div_vld_reg[j] <= div_vld_reg[j-1];
            end
            p1_vld_reg  <= div_vld_reg[QW];
            p2_vld_reg  <= p1_vld_reg;
            p3_vld_reg  <= p2_vld_reg;
            p4_vld_reg  <= p3_vld_reg;
            p5_vld_reg  <= p4_vld_reg;
            p6_vld_reg  <= p5_vld_reg;
            out_vld_reg <= p6_vld_reg;
        end
    end

`ifndef SYNTHESIS
    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (div_vld_reg[QW] && div_side_reg[QW].d != '0)
        |-> (CMP_W'(div_rem_reg[QW]) < CMP_W'({div_side_reg[QW].d, 1'b0})))
        else $error("divider remainder not below divisor");

    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        p3_vld_reg |-> (h_reg < TURN_UNITS))
        else $error("wrapped hue out of range");

    a_w_range: assert property (@(posedge aclk) disable iff (!aresetn)
        p4_vld_reg |-> (p4_w_reg <= SEC_W'(SECTOR_UNITS)))
        else $error("sector position out of range");

    a_mid_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        p6_vld_reg |-> (CH_W'(p6_t_reg >> DIV15_SH) <= p6_side_reg.d))
        else $error("middle channel exceeds channel spread");
`endif

endmodule
`default_nettype wire
